FILE: src/sdcsd_pkg.sv
// ----------------------------------------------------------------------------
// sdcsd_pkg
// Shared widths, field codes and constant tables for the SD CSD register
// decoder.
// ----------------------------------------------------------------------------
package sdcsd_pkg;

  // Structure version codes held in bits 127:126.
  localparam logic [1:0] CSD_VER_STD = 2'd0;
  localparam logic [1:0] CSD_VER_HC  = 2'd1;

  // Field widths of one result.
  localparam int unsigned ACC_TIME_W = 27;
  localparam int unsigned ACC_CLK_W  = 15;
  localparam int unsigned RATE_W     = 30;
  localparam int unsigned CCC_W      = 12;
  localparam int unsigned CAP_W      = 33;
  localparam int unsigned BLK_W      = 4;
  localparam int unsigned SPEED_W    = 3;
  localparam int unsigned FLAGS_W    = 4;

  // Widths of the table entries.
  localparam int unsigned MANT_W     = 7;
  localparam int unsigned RATE_EXP_W = 24;
  localparam int unsigned ACC_EXP_W  = 20;

  // Fixed values reported for high capacity cards.
  localparam logic [BLK_W-1:0]   HC_BLOCK_BITS = 4'd9;
  localparam logic [SPEED_W-1:0] HC_SPEED      = 3'd4;

  // Scale factor applied to NSAC to give access_clocks.
  localparam logic [6:0] NSAC_UNIT = 7'd100;

  // Mantissa table shared by TAAC and TRAN_SPEED, in tenths.
  function automatic logic [MANT_W-1:0] mant_lut(input logic [3:0] code);
    logic [MANT_W-1:0] v;
    case (code)
      4'd0:    v = 7'd0;
      4'd1:    v = 7'd10;
      4'd2:    v = 7'd12;
      4'd3:    v = 7'd13;
      4'd4:    v = 7'd15;
      4'd5:    v = 7'd20;
      4'd6:    v = 7'd25;
      4'd7:    v = 7'd30;
      4'd8:    v = 7'd35;
      4'd9:    v = 7'd40;
      4'd10:   v = 7'd45;
      4'd11:   v = 7'd50;
      4'd12:   v = 7'd55;
      4'd13:   v = 7'd60;
      4'd14:   v = 7'd70;
      4'd15:   v = 7'd80;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

  // Transfer rate unit; the upper four codes are reserved and give zero.
  function automatic logic [RATE_EXP_W-1:0] rate_exp_lut(input logic [2:0] code);
    logic [RATE_EXP_W-1:0] v;
    case (code)
      3'd0:    v = 24'd10000;
      3'd1:    v = 24'd100000;
      3'd2:    v = 24'd1000000;
      3'd3:    v = 24'd10000000;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Access time unit already divided by ten. The smallest unit does not
  // divide evenly and is handled by its own table.
  function automatic logic [ACC_EXP_W-1:0] acc_exp_div10_lut(input logic [2:0] code);
    logic [ACC_EXP_W-1:0] v;
    case (code)
      3'd1:    v = 20'd1;
      3'd2:    v = 20'd10;
      3'd3:    v = 20'd100;
      3'd4:    v = 20'd1000;
      3'd5:    v = 20'd10000;
      3'd6:    v = 20'd100000;
      3'd7:    v = 20'd1000000;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Mantissa divided by ten and rounded up, for the one nanosecond unit.
  function automatic logic [3:0] mant_ceil10_lut(input logic [3:0] code);
    logic [3:0] v;
    case (code)
      4'd0:    v = 4'd0;
      4'd1:    v = 4'd1;
      4'd2:    v = 4'd2;
      4'd3:    v = 4'd2;
      4'd4:    v = 4'd2;
      4'd5:    v = 4'd2;
      4'd6:    v = 4'd3;
      4'd7:    v = 4'd3;
      4'd8:    v = 4'd4;
      4'd9:    v = 4'd4;
      4'd10:   v = 4'd5;
      4'd11:   v = 4'd5;
      4'd12:   v = 4'd6;
      4'd13:   v = 4'd6;
      4'd14:   v = 4'd7;
      4'd15:   v = 4'd8;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/sd_csd_register_decoder_unit.sv
// ----------------------------------------------------------------------------
// sd_csd_register_decoder_unit
// Decodes one 128-bit SD card CSD register into timing, rate, capacity and
// block parameters.
// ----------------------------------------------------------------------------
//
//   Channel | Signals                            | Payload
//   --------+------------------------------------+-----------------------------
//   in      | in_valid, in_stall (driven here)   | resp_high, resp_low
//   out     | out_valid, out_stall (from sink)   | recognised .. access_flags
//
// A request is registered in the input register on acceptance, and its result
// is registered in the result register when that register moves.
// One request is accepted in every cycle while the output is not stalled.
// Reset clears both valid flags; the payload registers are not reset.
// A stall on the output holds the result and, once the input register is
// also full, is passed back to the input as in_stall.
// ----------------------------------------------------------------------------
module sd_csd_register_decoder_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [63:0]                        resp_high,
  input  logic [63:0]                        resp_low,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               recognised,
  output logic [1:0]                         csd_version,
  output logic [sdcsd_pkg::ACC_TIME_W-1:0]   access_time_ns,
  output logic [sdcsd_pkg::ACC_CLK_W-1:0]    access_clocks,
  output logic [sdcsd_pkg::RATE_W-1:0]       max_rate,
  output logic [sdcsd_pkg::CCC_W-1:0]        command_classes,
  output logic [sdcsd_pkg::CAP_W-1:0]        capacity_blocks,
  output logic [sdcsd_pkg::BLK_W-1:0]        read_block_bits,
  output logic [sdcsd_pkg::BLK_W-1:0]        write_block_bits,
  output logic [sdcsd_pkg::SPEED_W-1:0]      write_speed_factor,
  output logic [sdcsd_pkg::FLAGS_W-1:0]      access_flags
);
  import sdcsd_pkg::*;

  // Input register.
  logic        s1_valid;
  logic [63:0] hi;
  logic [63:0] lo;

  // Stage control.
  logic advance;
  logic load;

  // Decoded fields of the registered word.
  logic [1:0]              ver;
  logic                    is_std;
  logic                    is_hc;
  logic [2:0]              taac_exp;
  logic [3:0]              taac_mant;
  logic [2:0]              rate_exp_code;
  logic [3:0]              rate_mant_code;
  logic [11:0]             c_size_std;
  logic [2:0]              c_mult;
  logic [21:0]             c_size_hc;
  logic [ACC_EXP_W+MANT_W-1:0]  acc_prod;
  logic [RATE_EXP_W+MANT_W-1:0] rate_prod;
  logic [14:0]             nsac_prod;
  logic [CAP_W-1:0]        cap_std;
  logic [CAP_W-1:0]        cap_hc;

  // Next result values.
  logic                    recognised_next;
  logic [ACC_TIME_W-1:0]   access_time_next;
  logic [ACC_CLK_W-1:0]    access_clocks_next;
  logic [RATE_W-1:0]       max_rate_next;
  logic [CCC_W-1:0]        ccc_next;
  logic [CAP_W-1:0]        capacity_next;
  logic [BLK_W-1:0]        read_bits_next;
  logic [BLK_W-1:0]        write_bits_next;
  logic [SPEED_W-1:0]      speed_next;
  logic [FLAGS_W-1:0]      flags_next;

  // The result register moves when it is empty or being taken; the input
  // register takes a request when it is empty or moving on.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign load     = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hi <= resp_high;
      lo <= resp_low;
    end
  end

  // Field extraction; the register bit n sits at hi[n-64] or lo[n].
  assign ver            = hi[63:62];
  assign is_std         = (ver == CSD_VER_STD);
  assign is_hc          = (ver == CSD_VER_HC);
  assign taac_mant      = hi[54:51];
  assign taac_exp       = hi[50:48];
  assign rate_mant_code = hi[38:35];
  assign rate_exp_code  = hi[34:32];
  assign c_size_std     = {hi[9:0], lo[63:62]};
  assign c_mult         = lo[49:47];
  assign c_size_hc      = {hi[5:0], lo[63:48]};

  // Access time, rounded up to whole nanoseconds. Units of 10 ns and above
  // divide by ten exactly, so the division is folded into the unit table.
  assign acc_prod = {{MANT_W{1'b0}}, acc_exp_div10_lut(taac_exp)} *
                    {{ACC_EXP_W{1'b0}}, mant_lut(taac_mant)};

  // Transfer rate and access clocks.
  assign rate_prod = {{MANT_W{1'b0}}, rate_exp_lut(rate_exp_code)} *
                     {{RATE_EXP_W{1'b0}}, mant_lut(rate_mant_code)};
  assign nsac_prod = {7'd0, hi[47:40]} * {8'd0, NSAC_UNIT};

  // Capacity for both structure versions, kept at full width.
  assign cap_std = ({21'd0, c_size_std} + CAP_W'(1)) << ({2'd0, c_mult} + 5'd2);
  assign cap_hc  = ({11'd0, c_size_hc} + CAP_W'(1)) << 10;

  // Select the result fields by structure version.
  always_comb begin
    recognised_next    = 1'b0;
    access_time_next   = '0;
    access_clocks_next = '0;
    max_rate_next      = '0;
    ccc_next           = '0;
    capacity_next      = '0;
    read_bits_next     = '0;
    write_bits_next    = '0;
    speed_next         = '0;
    flags_next         = '0;
    if (is_std || is_hc) begin
      recognised_next = 1'b1;
      max_rate_next   = rate_prod[RATE_W-1:0];
      ccc_next        = hi[31:20];
    end
    if (is_std) begin
      if (taac_exp == 3'd0) begin
        access_time_next = {23'd0, mant_ceil10_lut(taac_mant)};
      end else begin
        access_time_next = acc_prod[ACC_TIME_W-1:0];
      end
      access_clocks_next = nsac_prod;
      capacity_next      = cap_std;
      read_bits_next     = hi[19:16];
      write_bits_next    = lo[25:22];
      speed_next         = lo[28:26];
      flags_next         = {lo[21], hi[13], hi[14], hi[15]};
    end else if (is_hc) begin
      capacity_next   = cap_hc;
      read_bits_next  = HC_BLOCK_BITS;
      write_bits_next = HC_BLOCK_BITS;
      speed_next      = HC_SPEED;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      recognised         <= recognised_next;
      csd_version        <= ver;
      access_time_ns     <= access_time_next;
      access_clocks      <= access_clocks_next;
      max_rate           <= max_rate_next;
      command_classes    <= ccc_next;
      capacity_blocks    <= capacity_next;
      read_block_bits    <= read_bits_next;
      write_block_bits   <= write_bits_next;
      write_speed_factor <= speed_next;
      access_flags       <= flags_next;
    end
  end

endmodule
